/* rtl/longest_palindrome_finder_core_assert.svh */
// ----------------------------------------------------------------------------
// longest_palindrome_finder_core_assert
// Assertion macros for the longest palindrome finder core.
// ----------------------------------------------------------------------------
// LPF_ASSERT_SAME checks the consequent in the cycle of the antecedent,
// LPF_ASSERT_NEXT checks it in the cycle after.
`ifndef LONGEST_PALINDROME_FINDER_CORE_ASSERT_SVH
`define LONGEST_PALINDROME_FINDER_CORE_ASSERT_SVH

`define LPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpf assertion failed");

`define LPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpf assertion failed");

`endif

/* rtl/lpf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared constants, payload types and controller/datapath signal groups of
// the longest palindrome finder.
// ----------------------------------------------------------------------------
package lpf_pkg;

   localparam int MAX_LEN_DEFAULT = 1024;
   localparam int CHAR_W          = 8;
   localparam int PAL_START_W     = 10;
   localparam int PAL_LENGTH_W    = 11;

   typedef struct packed {
      logic [CHAR_W-1:0] char_byte;
      logic              last_char;
   } req_type;

   typedef struct packed {
      logic [PAL_START_W-1:0]  pal_start;
      logic [PAL_LENGTH_W-1:0] pal_length;
      logic                    overflowed;
   } rsp_type;

   typedef struct packed {
      logic write_byte;
      logic start_search;
      logic read_pair;
      logic step_out;
      logic end_center;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic in_bounds;
      logic pair_match;
      logic last_center;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

/* rtl/lpf_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpf_stream_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface lpf_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/longest_palindrome_finder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// longest_palindrome_finder_core
// Longest palindromic substring by expansion around every center.
// ----------------------------------------------------------------------------
// Bytes stream in on req_chan, one per cycle while no search runs, into a
// MAX_LEN byte buffer; bytes past MAX_LEN are dropped and flagged. The byte
// marked last_char starts the search: each position is tried as an odd
// center, then as the even center to its right, and the first longest
// palindrome wins. One response gives its start, length and the overflow
// flag. Every pair compare is a read of the dual-read buffer in ST_CHECK,
// then a compare in ST_COMPARE; a center ends at its first mismatching
// compare, or in ST_CHECK when it runs off the end of the string, and the
// winner is loaded into the response register from ST_FINISH once that
// register is free. No byte is taken during the search; a response waiting
// on rsp_chan does not hold up the bytes of the next string.
module longest_palindrome_finder_core #(
   parameter int MAX_LEN = lpf_pkg::MAX_LEN_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   lpf_stream_if.sink    req_chan,
   lpf_stream_if.source  rsp_chan
);

`include "longest_palindrome_finder_core_assert.svh"

   lpf_pkg::dp_cmd_type    cmd;
   lpf_pkg::dp_status_type sts;
   lpf_pkg::rsp_type       rsp_data;
   logic                   req_ready;
   logic                   rsp_valid;
   logic                   req_last;
   logic                   req_fire;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = rsp_data;
   assign req_last       = req_chan.data.last_char;
   assign req_fire       = req_chan.valid && req_ready;

   lpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_last),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpf_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_chan.data),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `LPF_ASSERT_NEXT(last_closes_intake, clock, reset, req_fire && req_last, !req_ready)
   `LPF_ASSERT_NEXT(byte_keeps_intake, clock, reset, req_fire && !req_last, req_ready)
   `LPF_ASSERT_SAME(rsp_after_search, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule
`default_nettype wire

/* rtl/lpf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpf_ctrl
// Sequencer: takes bytes, then walks every center, one buffer pair compare
// per ST_CHECK/ST_COMPARE pass, and hands the winner to the output register.
// ----------------------------------------------------------------------------
module lpf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   input  lpf_pkg::dp_status_type sts,
   output lpf_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CHECK   = 4'b0010,
      ST_COMPARE = 4'b0100,
      ST_FINISH  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.write_byte = 1'b1;
               if (req_last) begin
                  cmd.start_search = 1'b1;
                  state_in         = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sts.in_bounds) begin
               cmd.read_pair = 1'b1;
               state_in      = ST_COMPARE;
            end else begin
               cmd.end_center = 1'b1;
               if (sts.last_center) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_COMPARE: begin
            if (sts.pair_match) begin
               cmd.step_out = 1'b1;
               state_in     = ST_CHECK;
            end else begin
               cmd.end_center = 1'b1;
               state_in       = sts.last_center ? ST_FINISH : ST_CHECK;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/lpf_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpf_datapath
// Text buffer with one write and two registered read ports, expansion
// pointers, running best palindrome and the response register.
// ----------------------------------------------------------------------------
module lpf_datapath #(
   parameter int MAX_LEN = lpf_pkg::MAX_LEN_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpf_pkg::dp_cmd_type    cmd,
   output lpf_pkg::dp_status_type sts,
   input  lpf_pkg::req_type       req_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output lpf_pkg::rsp_type       rsp_data
);

   localparam int AW      = $clog2(MAX_LEN);
   localparam int CW      = $clog2(MAX_LEN + 1);
   localparam int CharW   = lpf_pkg::CHAR_W;
   localparam int StartW  = lpf_pkg::PAL_START_W;
   localparam int LengthW = lpf_pkg::PAL_LENGTH_W;

   logic [CharW-1:0] text_mem [MAX_LEN];

   logic [CW-1:0]    count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [AW-1:0]    center_ff, center_in;
   logic             odd_ff, odd_in;
   // lo is kept plus one so that running off the left end reads as zero
   logic [CW-1:0]    lo_p1_ff, lo_p1_in;
   logic [CW-1:0]    hi_ff, hi_in;
   logic [AW-1:0]    best_start_ff, best_start_in;
   logic [CW-1:0]    best_length_ff, best_length_in;
   logic [CharW-1:0] rd_lo_ff, rd_hi_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lpf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [CW-1:0]    center_p1;
   logic [CW-1:0]    span;
   logic [AW-1:0]    rd_lo_addr;
   logic [AW-1:0]    rd_hi_addr;
   logic [CW-1:0]    lo_addr_wide;
   logic             buffer_full;

   assign center_p1    = CW'(center_ff) + CW'(1);
   assign span         = hi_ff - lo_p1_ff;
   assign lo_addr_wide = lo_p1_ff - CW'(1);
   assign rd_lo_addr   = lo_addr_wide[AW-1:0];
   assign rd_hi_addr   = hi_ff[AW-1:0];
   assign buffer_full  = (count_ff == CW'(MAX_LEN));

   assign sts.in_bounds   = (lo_p1_ff != '0) && (hi_ff < count_ff);
   assign sts.pair_match  = (rd_lo_ff == rd_hi_ff);
   assign sts.last_center = !odd_ff && (center_p1 == count_ff);
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      center_in      = center_ff;
      odd_in         = odd_ff;
      lo_p1_in       = lo_p1_ff;
      hi_in          = hi_ff;
      best_start_in  = best_start_ff;
      best_length_in = best_length_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      if (cmd.write_byte) begin
         // drop the byte once the buffer is full
         if (buffer_full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end

      if (cmd.start_search) begin
         center_in      = '0;
         odd_in         = 1'b1;
         lo_p1_in       = CW'(1);
         hi_in          = '0;
         best_start_in  = '0;
         best_length_in = '0;
      end

      if (cmd.step_out) begin
         lo_p1_in = lo_p1_ff - CW'(1);
         hi_in    = hi_ff + CW'(1);
      end

      if (cmd.end_center) begin
         // strictly longer only, so the earliest center keeps a tie
         if (span > best_length_ff) begin
            best_length_in = span;
            best_start_in  = lo_p1_ff[AW-1:0];
         end
         if (odd_ff) begin
            odd_in   = 1'b0;
            lo_p1_in = center_p1;
            hi_in    = center_p1;
         end else begin
            odd_in    = 1'b1;
            center_in = center_p1[AW-1:0];
            lo_p1_in  = center_p1 + CW'(1);
            hi_in     = center_p1;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load_out) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.pal_start  = StartW'(best_start_ff);
         rsp_data_in.pal_length = LengthW'(best_length_ff);
         rsp_data_in.overflowed = overflow_ff;
         count_in               = '0;
         overflow_in            = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         center_ff      <= '0;
         odd_ff         <= 1'b1;
         lo_p1_ff       <= '0;
         hi_ff          <= '0;
         best_start_ff  <= '0;
         best_length_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         center_ff      <= center_in;
         odd_ff         <= odd_in;
         lo_p1_ff       <= lo_p1_in;
         hi_ff          <= hi_in;
         best_start_ff  <= best_start_in;
         best_length_ff <= best_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.write_byte && !buffer_full) begin
         text_mem[count_ff[AW-1:0]] <= req_data.char_byte;
      end
      if (cmd.read_pair) begin
         rd_lo_ff <= text_mem[rd_lo_addr];
         rd_hi_ff <= text_mem[rd_hi_addr];
      end
   end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Stimulus and scoreboard for longest_palindrome_finder_core: strings go in
// byte by byte, and each closing byte predicts a start/length/overflow
// response that is checked in order against the response channel.
// ----------------------------------------------------------------------------
module testbench;

   localparam int BUF_DEPTH = lpf_pkg::MAX_LEN_DEFAULT;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpf_stream_if #(.payload_type(lpf_pkg::req_type)) req_chan ();
   lpf_stream_if #(.payload_type(lpf_pkg::rsp_type)) rsp_chan ();

   longest_palindrome_finder_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   logic [7:0] held_text [0:BUF_DEPTH-1];
   int         held_count = 0;
   bit         chars_lost = 1'b0;

   lpf_pkg::rsp_type expected_spans [$];
   logic [7:0]       draft [$];
   int               error_count = 0;
   int               send_idle_pct = 0;
   int               rsp_stall_pct = 0;

   always #5 clock = ~clock;

   initial begin
      #60000000;
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Store one byte; on the closing byte, expand every center in order.
   function automatic void absorb_char(input logic [7:0] ch, input logic last,
                                       output bit has_span,
                                       output lpf_pkg::rsp_type span);
      int top, where, lo, hi, len, widest;
      has_span = 1'b0;
      span = '0;
      if (held_count < BUF_DEPTH) begin
         held_text[held_count] = ch;
         held_count++;
      end else begin
         chars_lost = 1'b1;
      end
      if (!last) return;
      top = 0;
      where = 0;
      for (int i = 0; i < held_count; i++) begin
         widest = 0;
         for (int k = 0; k < 2; k++) begin
            lo = i;
            hi = i + k;
            while (lo >= 0 && hi < held_count && held_text[lo] == held_text[hi]) begin
               lo--;
               hi++;
            end
            len = hi - lo - 1;
            if (len > widest) widest = len;
         end
         // strictly longer only, so the earliest center keeps a tie
         if (widest > top) begin
            top = widest;
            where = i - (widest - 1) / 2;
         end
      end
      span.pal_start  = where[lpf_pkg::PAL_START_W-1:0];
      span.pal_length = top[lpf_pkg::PAL_LENGTH_W-1:0];
      span.overflowed = chars_lost;
      has_span = 1'b1;
      held_count = 0;
      chars_lost = 1'b0;
   endfunction

   always @(posedge clock) begin
      lpf_pkg::rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_spans.size() == 0) begin
            $display("%0t: unexpected response: expected none, got start %0d length %0d ovf %0b",
                     $time, rsp_chan.data.pal_start, rsp_chan.data.pal_length,
                     rsp_chan.data.overflowed);
            error_count++;
         end else begin
            want = expected_spans.pop_front();
            if (rsp_chan.data.pal_start !== want.pal_start) begin
               $display("%0t: pal_start mismatch: expected %0d, got %0d",
                        $time, want.pal_start, rsp_chan.data.pal_start);
               error_count++;
            end
            if (rsp_chan.data.pal_length !== want.pal_length) begin
               $display("%0t: pal_length mismatch: expected %0d, got %0d",
                        $time, want.pal_length, rsp_chan.data.pal_length);
               error_count++;
            end
            if (rsp_chan.data.overflowed !== want.overflowed) begin
               $display("%0t: overflowed mismatch: expected %0b, got %0b",
                        $time, want.overflowed, rsp_chan.data.overflowed);
               error_count++;
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic push_char(input logic [7:0] ch, input logic last);
      bit               has_span;
      lpf_pkg::rsp_type span;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= '{char_byte: ch, last_char: last};
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      absorb_char(ch, last, has_span, span);
      if (has_span) expected_spans.push_back(span);
      @(negedge clock);
   endtask

   task automatic send_draft();
      foreach (draft[i]) push_char(draft[i], i == draft.size() - 1);
   endtask

   // Drop valid and hold until every pending response has come back.
   task automatic wait_all_responses();
      req_chan.valid <= 1'b0;
      while (expected_spans.size() != 0) @(negedge clock);
   endtask

   task automatic build_draft();
      int         n, kind, core, at;
      logic [7:0] alpha [3];
      draft.delete();
      n = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      kind = $urandom_range(9);
      foreach (alpha[j]) alpha[j] = 8'($urandom_range(255));
      for (int i = 0; i < n; i++) begin
         case (kind) inside
            [0:1]:   draft.push_back(alpha[$urandom_range(1)]);
            [2:3]:   draft.push_back(alpha[$urandom_range(2)]);
            7:       draft.push_back(alpha[0]);
            default: draft.push_back(8'($urandom_range(255)));
         endcase
      end
      // plant a mirrored run inside random bytes
      if (kind >= 8 && n >= 2) begin
         core = $urandom_range(2, n);
         at = $urandom_range(0, n - core);
         for (int j = 0; j < core / 2; j++) draft[at + core - 1 - j] = draft[at + j];
      end
   endtask

   task automatic test_edge_strings();
      draft = '{8'h00};                         send_draft();
      draft = '{8'hFF};                         send_draft();
      draft = '{8'h55, 8'h55};                  send_draft();
      draft = '{8'h00, 8'hFF};                  send_draft();
      draft = '{8'hAA, 8'h01, 8'hAA};           send_draft();
      draft = '{8'h7F, 8'h80, 8'h80, 8'h7F};    send_draft();
      // equal odd runs: the earlier one wins
      draft = '{8'h01, 8'h02, 8'h01, 8'h03, 8'h03, 8'h03}; send_draft();
      draft = '{8'h09, 8'h04, 8'h04, 8'h09};    send_draft();
   endtask

   task automatic test_full_buffer_overflow();
      wait_all_responses();
      // fill the buffer with one palindrome; drop the bytes after it, the closing one too
      draft.delete();
      for (int i = 0; i < BUF_DEPTH / 2; i++) draft.push_back(8'($urandom_range(255)));
      for (int i = BUF_DEPTH / 2 - 1; i >= 0; i--) draft.push_back(draft[i]);
      for (int i = 0; i < 2; i++) draft.push_back(8'($urandom_range(255)));
      send_draft();
      wait_all_responses();
   endtask

   task automatic test_random_strings(input int idle_pct, input int stall_pct,
                                      input int char_budget);
      int sent;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < char_budget) begin
         build_draft();
         send_draft();
         sent += draft.size();
      end
      wait_all_responses();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_edge_strings();
      test_full_buffer_overflow();
      test_random_strings(0, 0, 25);
      test_random_strings(71, 0, 25);
      test_random_strings(0, 71, 25);
      test_random_strings(17, 17, 25);
      wait_all_responses();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* longest_palindrome_finder_core.f */
+incdir+rtl
rtl/lpf_pkg.sv
rtl/lpf_stream_if.sv
rtl/lpf_ctrl.sv
rtl/lpf_datapath.sv
rtl/longest_palindrome_finder_core.sv
tb/testbench.sv
